// ===== src/intc64_pkg.sv =====
// package with the constants, command codes and types of the 64-source interrupt controller
package intc64_pkg;

  // bank geometry
  localparam int SOURCES_PER_BANK = 32;
  localparam int NUM_SOURCES      = 2 * SOURCES_PER_BANK;
  localparam int SRC_W            = $clog2(NUM_SOURCES);

  // fixed field widths
  localparam int CMD_W      = 3;
  localparam int DATA_W     = 32;
  localparam int RAW_W      = 64;
  localparam int NEXT_W     = 6;
  localparam int CORE_W     = 2;
  localparam int FAST_W     = 8;
  localparam int FAST_SEL_W = 7;
  localparam int FAST_EN    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_SET_BANK1   = 3'd0,
    CMD_SET_BANK2   = 3'd1,
    CMD_CLR_BANK1   = 3'd2,
    CMD_CLR_BANK2   = 3'd3,
    CMD_WRITE_FAST  = 3'd4,
    CMD_READ_BANK1  = 3'd5,
    CMD_READ_BANK2  = 3'd6,
    CMD_NOP         = 3'd7
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IRQ_ROUTE = 2'd0,
    CFG_FIQ_ROUTE = 2'd1,
    CFG_SPARE2    = 2'd2,
    CFG_SPARE3    = 2'd3
  } cfg_idx_t;

endpackage

// ===== src/intc64_if.sv =====
// valid/ready channel interfaces for source levels, results and configuration writes
interface intc64_in_if;
  import intc64_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [DATA_W-1:0]     write_data;
  logic [RAW_W-1:0]      raw_sources;
  modport source (output valid, command, write_data, raw_sources, input ready);
  modport sink   (input valid, command, write_data, raw_sources, output ready);
endinterface

interface intc64_out_if;
  import intc64_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [DATA_W-1:0]     read_data;
  logic                  irq_active;
  logic                  fiq_active;
  logic [NEXT_W-1:0]     next_source;
  logic                  next_valid;
  logic [CORE_W-1:0]     irq_core;
  logic [CORE_W-1:0]     fiq_core;
  modport source (output valid, read_data, irq_active, fiq_active, next_source,
                  next_valid, irq_core, fiq_core, input ready);
  modport sink   (input valid, read_data, irq_active, fiq_active, next_source,
                  next_valid, irq_core, fiq_core, output ready);
endinterface

interface intc64_cfg_if;
  import intc64_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/interrupt_controller_64_source_unit.sv =====
// top level of the 64-source interrupt controller with enable masks and fast interrupt select
// result: registered in the output register and presented in the cycle after its item transfer
// throughput: one item per cycle; a new item is taken whenever the output register is
//   empty or being drained in the same cycle
// reset (rst_n low, synchronous): enable mask, fast control and route cores clear to zero,
//   the output register is emptied; configuration writes are taken every cycle
module interrupt_controller_64_source_unit (
  input logic         clk,
  input logic         rst_n,
  intc64_in_if.sink   in_ch,
  intc64_out_if.source out_ch,
  intc64_cfg_if.sink  cfg_ch
);
  import intc64_pkg::*;

  // state
  logic [NUM_SOURCES-1:0]      enable_mask_r, enable_mask_nxt;
  logic [FAST_W-1:0]           fast_control_r, fast_control_nxt;
  logic [CORE_W-1:0]           irq_route_r;
  logic [CORE_W-1:0]           fiq_route_r;

  // output register
  logic                        out_valid_r;
  logic [DATA_W-1:0]           read_data_r, read_data_nxt;
  logic                        irq_active_r, irq_active_nxt;
  logic                        fiq_active_r, fiq_active_nxt;
  logic [NEXT_W-1:0]           next_source_r, next_source_nxt;
  logic                        next_valid_r, next_valid_nxt;

  // combinational helpers
  logic                        in_xfer;
  cmd_t                        cmd;
  logic [SOURCES_PER_BANK-1:0] wr_bits;
  logic [NUM_SOURCES-1:0]      raw_s;
  logic [NUM_SOURCES-1:0]      pend;
  logic [NUM_SOURCES-1:0]      first_hot;
  logic [SRC_W-1:0]            first_idx;
  logic [FAST_SEL_W-1:0]       fast_sel;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign cmd     = cmd_t'(in_ch.command);
  assign wr_bits = in_ch.write_data[SOURCES_PER_BANK-1:0];
  assign raw_s   = in_ch.raw_sources[NUM_SOURCES-1:0];

  // command applies to the mask and fast control first
  always_comb begin
    enable_mask_nxt  = enable_mask_r;
    fast_control_nxt = fast_control_r;
    unique case (cmd)
      CMD_SET_BANK1: enable_mask_nxt[SOURCES_PER_BANK-1:0] =
                       enable_mask_r[SOURCES_PER_BANK-1:0] | wr_bits;
      CMD_SET_BANK2: enable_mask_nxt[NUM_SOURCES-1:SOURCES_PER_BANK] =
                       enable_mask_r[NUM_SOURCES-1:SOURCES_PER_BANK] | wr_bits;
      CMD_CLR_BANK1: enable_mask_nxt[SOURCES_PER_BANK-1:0] =
                       enable_mask_r[SOURCES_PER_BANK-1:0] & ~wr_bits;
      CMD_CLR_BANK2: enable_mask_nxt[NUM_SOURCES-1:SOURCES_PER_BANK] =
                       enable_mask_r[NUM_SOURCES-1:SOURCES_PER_BANK] & ~wr_bits;
      CMD_WRITE_FAST: fast_control_nxt = in_ch.write_data[FAST_W-1:0];
      default: ;
    endcase
  end

  // pending word, isolate lowest set bit and encode it
  assign pend      = raw_s & enable_mask_nxt;
  assign first_hot = pend & (~pend + 1'b1);

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (first_hot[i]) begin
        first_idx = first_idx | SRC_W'(i);
      end
    end
  end

  // result fields from the updated state
  assign fast_sel = fast_control_nxt[FAST_SEL_W-1:0];

  always_comb begin
    read_data_nxt = '0;
    if (cmd == CMD_READ_BANK1) begin
      read_data_nxt = DATA_W'(pend[SOURCES_PER_BANK-1:0]);
    end else if (cmd == CMD_READ_BANK2) begin
      read_data_nxt = DATA_W'(pend[NUM_SOURCES-1:SOURCES_PER_BANK]);
    end
    irq_active_nxt  = |pend;
    next_valid_nxt  = |pend;
    next_source_nxt = NEXT_W'(first_idx);
    fiq_active_nxt  = 1'b0;
    if (fast_control_nxt[FAST_EN] && (fast_sel < FAST_SEL_W'(NUM_SOURCES))) begin
      fiq_active_nxt = raw_s[fast_sel[SRC_W-1:0]];
    end
  end

  // mask and fast control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r  <= '0;
      fast_control_r <= '0;
    end else if (in_xfer) begin
      enable_mask_r  <= enable_mask_nxt;
      fast_control_r <= fast_control_nxt;
    end
  end

  // route core configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_route_r <= '0;
      fiq_route_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_IRQ_ROUTE: irq_route_r <= cfg_ch.data[CORE_W-1:0];
        CFG_FIQ_ROUTE: fiq_route_r <= cfg_ch.data[CORE_W-1:0];
        default: ;
      endcase
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      read_data_r   <= read_data_nxt;
      irq_active_r  <= irq_active_nxt;
      fiq_active_r  <= fiq_active_nxt;
      next_source_r <= next_source_nxt;
      next_valid_r  <= next_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = read_data_r;
  assign out_ch.irq_active  = irq_active_r;
  assign out_ch.fiq_active  = fiq_active_r;
  assign out_ch.next_source = next_source_r;
  assign out_ch.next_valid  = next_valid_r;
  assign out_ch.irq_core    = irq_route_r;
  assign out_ch.fiq_core    = fiq_route_r;

`ifndef SYNTHESIS
  // encoder flag agrees with the irq line
  a_next_valid_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (next_valid_r == irq_active_r))
    else $error("next_valid differs from irq_active");

  // a nonzero pending read means some source is pending
  a_read_implies_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (read_data_r != '0)) |-> irq_active_r)
    else $error("pending word read without irq_active");

  // fast line only while fast control is enabled
  a_fiq_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fiq_active_r) |-> fast_control_r[FAST_EN])
    else $error("fiq_active with fast control disabled");

  // reported source lies inside the banks
  a_next_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && next_valid_r) |-> (next_source_r <= NEXT_W'(NUM_SOURCES - 1)))
    else $error("next_source beyond the banks");

  // mask is clear right after reset
  a_mask_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (enable_mask_r == '0))
    else $error("enable mask not cleared by reset");
`endif

endmodule
